### src/shabs_pkg.sv
package shabs_pkg;

  // Input item: absorb one byte or finish the message.
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  // Output item: one digest word.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the sequencer to the schedule window.
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       expand;
  } sched_ctrl_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;
    logic       round;
    logic       add;
    logic       init;
    logic [5:0] round_idx;
    logic [2:0] rd_idx;
  } core_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/shabs_chan_if.sv
interface shabs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/shabs_sched.sv
module shabs_sched (
  input  logic                  clk_i,
  input  shabs_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]           w_o
);
  import shabs_pkg::*;

  // Sixteen-word window: it holds the block while bytes arrive and then
  // slides through the message schedule, one word per round.
  logic [31:0] win_q [16];
  logic [31:0] new_word_d;
  logic [31:0] sig0;
  logic [31:0] sig1;

  assign sig0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
  assign sig1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
  assign new_word_d = win_q[0] + sig0 + win_q[9] + sig1;

  assign w_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], ctrl_i.data};
    end else if (ctrl_i.expand) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= new_word_d;
    end
  end

endmodule

### src/shabs_core.sv
module shabs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shabs_pkg::core_ctrl_t ctrl_i,
  input  logic [31:0]          w_i,
  output logic [31:0]          digest_o
);
  import shabs_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];

  logic [31:0] big1;
  logic [31:0] choose;
  logic [31:0] big0;
  logic [31:0] major;
  logic [31:0] t1;
  logic [31:0] t2;

  assign big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + big1 + choose + ROUND_K[ctrl_i.round_idx] + w_i;
  assign t2     = big0 + major;

  assign digest_o = h_q[ctrl_i.rd_idx];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= h_q;
    end else if (ctrl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_INIT;
    end else if (ctrl_i.init) begin
      h_q <= H_INIT;
    end else if (ctrl_i.add) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

endmodule

### src/sha256_byte_stream_hasher.sv
// Channel  Direction  Payload                                Transaction
// req_i    in         command, data_byte                     valid && ready
// rsp_o    out        digest_word, word_index, last_word     valid && ready
//
// An accepted absorb byte enters the window; a byte completing a 64-byte
// block starts 64 rounds of the shared round unit and the chaining add.
// A finish pushes 9 to 72 padding bytes, one per cycle outside its one or
// two compressions, then offers eight digest words, one per transaction.
// Reset loads the initial hash values and clears all counters at once.
// Input is not accepted while a block is compressed, padding runs or
// digest words wait; a stalled output simply holds the current word.
module sha256_byte_stream_hasher (
  input logic         clk_i,
  input logic         rst_ni,
  shabs_chan_if.sink   req_i,
  shabs_chan_if.source rsp_o
);
  import shabs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_e;

  state_e      state_q;
  phase_e      phase_q;
  logic [5:0]  fill_q;
  logic [63:0] count_q;
  logic [63:0] len_q;
  logic        pad_q;
  logic        final_q;
  logic [5:0]  round_q;
  logic [2:0]  idx_q;

  logic        in_accept;
  logic        out_accept;
  logic        push;
  logic        pad_len;
  logic [7:0]  pad_byte;
  logic [7:0]  push_byte;
  logic [31:0] w_word;
  logic [31:0] digest_word;
  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;

  in_item_t  in_item;
  out_item_t out_item;

  assign in_item     = req_i.payload;
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_accept   = req_i.valid && req_i.ready;
  assign out_accept  = rsp_o.valid && rsp_o.ready;

  // Length bytes start once the fill reaches the length position.
  assign pad_len  = (phase_q == PH_LEN) || ((phase_q == PH_ZERO) && (fill_q == LENGTH_POS));
  assign pad_byte = (phase_q == PH_MARK) ? PAD_MARK :
                    pad_len ? len_q[{~fill_q[2:0], 3'b000} +: 8] : 8'h00;

  assign push      = (in_accept && (in_item.command == CMD_ABSORB)) || (state_q == ST_PAD);
  assign push_byte = (state_q == ST_PAD) ? pad_byte : in_item.data_byte;

  assign sched_ctrl.push   = push;
  assign sched_ctrl.data   = push_byte;
  assign sched_ctrl.expand = (state_q == ST_COMP);

  assign core_ctrl.load      = push && (fill_q == LAST_BYTE);
  assign core_ctrl.round     = (state_q == ST_COMP);
  assign core_ctrl.add       = (state_q == ST_ADD);
  assign core_ctrl.init      = out_accept && (idx_q == LAST_WORD);
  assign core_ctrl.round_idx = round_q;
  assign core_ctrl.rd_idx    = idx_q;

  shabs_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_word)
  );

  shabs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (core_ctrl),
    .w_i      (w_word),
    .digest_o (digest_word)
  );

  assign out_item.digest_word = digest_word;
  assign out_item.word_index  = idx_q;
  assign out_item.last_word   = (idx_q == LAST_WORD);
  assign rsp_o.payload        = out_item;
  assign rsp_o.valid          = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MARK;
      fill_q  <= '0;
      count_q <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      final_q <= 1'b0;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      if (push) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_item.command == CMD_FINISH) begin
              len_q   <= {count_q[60:0], 3'b000};
              phase_q <= PH_MARK;
              pad_q   <= 1'b1;
              state_q <= ST_PAD;
            end else begin
              count_q <= count_q + 64'd1;
              if (fill_q == LAST_BYTE) begin
                round_q <= '0;
                state_q <= ST_COMP;
              end
            end
          end
        end
        ST_PAD: begin
          if (phase_q == PH_MARK) begin
            phase_q <= PH_ZERO;
          end else if (pad_len) begin
            phase_q <= PH_LEN;
          end
          if (fill_q == LAST_BYTE) begin
            // The last length byte closes the final block of the message.
            if (pad_len) begin
              final_q <= 1'b1;
            end
            round_q <= '0;
            state_q <= ST_COMP;
          end
        end
        ST_COMP: begin
          round_q <= round_q + 6'd1;
          if (round_q == LAST_ROUND) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (final_q) begin
            idx_q   <= '0;
            state_q <= ST_OUT;
          end else if (pad_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_accept) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == LAST_WORD) begin
              count_q <= '0;
              pad_q   <= 1'b0;
              final_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
